### design/shd_pkg.sv
// ----------------------------------------------------------------------------
// shd_pkg
// shared types, constants and register indexes for the suitability block
// ----------------------------------------------------------------------------
package shd_pkg;

  localparam int unsigned ONE_Q16 = 65536;
  localparam int unsigned ANGLE_MAX = 23040;
  localparam int unsigned MOIST_TOL_DEFAULT = 13107;

  typedef enum logic [2:0] {
    REG_SLOPE_FULL = 3'd0,
    REG_SLOPE_ZERO = 3'd1,
    REG_MOIST_LOW  = 3'd2,
    REG_MOIST_HIGH = 3'd3,
    REG_ACTIVE     = 3'd4,
    REG_OVERUSE    = 3'd5,
    REG_BAND       = 3'd6,
    REG_HOLD       = 3'd7
  } reg_idx_t;

  localparam logic [1:0] ST_UNUSED     = 2'd0;
  localparam logic [1:0] ST_ACTIVE     = 2'd1;
  localparam logic [1:0] ST_OVERUSED   = 2'd2;
  localparam logic [1:0] ST_RECOVERING = 2'd3;

  typedef struct packed {
    logic [14:0] slope_full_limit;
    logic [14:0] slope_zero_limit;
    logic [16:0] moisture_low_edge;
    logic [16:0] moisture_high_edge;
    logic [16:0] active_level;
    logic [16:0] overuse_level;
    logic [16:0] band_width;
    logic [30:0] hold_time;
  } cfg_t;

  // word passed from the front to the back through the queue
  typedef struct packed {
    logic [16:0] suit;
    logic [30:0] time_q;
  } mid_t;

endpackage

### design/shd_divider.sv
// ----------------------------------------------------------------------------
// shd_divider
// restoring divider, one quotient bit per cycle, 17-bit quotient
// ----------------------------------------------------------------------------
module shd_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [16:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [16:0] quotient
);
  logic [4:0]  count;
  logic [16:0] rem;
  logic [16:0] low_bits;
  logic [16:0] quo;
  logic [16:0] dsr;
  logic [17:0] shifted;
  logic [18:0] trial;

  assign shifted  = {rem, low_bits[16]};
  assign trial    = {1'b0, shifted} - {2'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 5'd17;
      end else if (busy) begin
        count <= count - 5'd1;
        if (count == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial remainder plus the low dividend bits still to bring down
  // dividend < divisor * 2^17 always here
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, dividend[32:17]};
      low_bits <= dividend[16:0];
      quo      <= 17'd0;
      dsr      <= divisor;
    end else if (busy) begin
      low_bits <= {low_bits[15:0], 1'b0};
      if (!trial[18]) begin
        rem <= trial[16:0];
        quo <= {quo[15:0], 1'b1};
      end else begin
        rem <= shifted[16:0];
        quo <= {quo[15:0], 1'b0};
      end
    end
  end
endmodule

### design/shd_front.sv
// ----------------------------------------------------------------------------
// shd_front
// clamps a sample and computes suitability, serial divider for the slope ramp
// ----------------------------------------------------------------------------
module shd_front #(
  parameter int unsigned MOISTURE_TOLERANCE = shd_pkg::MOIST_TOL_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  shd_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  slope_angle,
  input  logic signed [17:0]  moisture_level,
  input  logic signed [31:0]  elapsed_time,
  output logic                mid_valid,
  input  logic                mid_full,
  output shd_pkg::mid_t       mid_word
);
  import shd_pkg::*;

  // reciprocal of the tolerance, exact for numerators d * 2^16 with d < tolerance
  localparam int unsigned TOL_SHIFT = 2 * $clog2(MOISTURE_TOLERANCE);
  localparam logic [33:0] TOL_RECIP =
    34'(((64'd1 << (16 + TOL_SHIFT)) / 64'(MOISTURE_TOLERANCE)) + 64'd1);

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_SDIV  = 5'b00010,
    F_MDIV  = 5'b00100,
    F_MUL   = 5'b01000,
    F_PUSH  = 5'b10000
  } fstate_t;

  fstate_t     st;
  logic [14:0] ang;
  logic [16:0] moist;
  logic [30:0] tq;
  logic [16:0] s_suit;
  logic [16:0] m_suit;
  logic [16:0] suit;
  logic        s_need;
  logic        m_need;
  logic [15:0] s_num;
  logic [16:0] s_den;
  logic [16:0] m_d;
  logic [16:0] tol;
  logic [49:0] m_prod;
  logic [16:0] m_q;
  logic        div_start;
  logic [32:0] div_dividend;
  logic [16:0] div_divisor;
  logic        div_busy;
  logic        div_done;
  logic [16:0] div_q;
  logic [14:0] ang_c;
  logic [16:0] moist_c;
  logic [33:0] prod;
  logic        in_acc;

  assign tol = 17'(MOISTURE_TOLERANCE);

  always_comb begin
    if (slope_angle < 16'sd0) ang_c = '0;
    else if (slope_angle > 16'sd23040) ang_c = 15'(ANGLE_MAX);
    else ang_c = slope_angle[14:0];
    if (moisture_level < 18'sd0) moist_c = '0;
    else if (moisture_level > 18'sd65536) moist_c = 17'(ONE_Q16);
    else moist_c = moisture_level[16:0];
  end

  // slope terms
  always_comb begin
    s_need = 1'b0;
    s_num  = {1'b0, ang - cfg.slope_full_limit};
    s_den  = {2'b0, cfg.slope_zero_limit - cfg.slope_full_limit};
    if (ang > cfg.slope_full_limit && ang < cfg.slope_zero_limit) s_need = 1'b1;
  end

  // moisture terms
  always_comb begin
    m_need = 1'b0;
    m_d    = '0;
    if (!(moist >= cfg.moisture_low_edge && moist <= cfg.moisture_high_edge)) begin
      m_d = moist < cfg.moisture_low_edge ? cfg.moisture_low_edge - moist
                                          : moist - cfg.moisture_high_edge;
      if (m_d < tol) m_need = 1'b1;
    end
  end

  assign m_prod = 50'(m_d[15:0]) * 50'(TOL_RECIP);
  assign m_q    = 17'(m_prod >> TOL_SHIFT);

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = st != F_IDLE;
  assign prod     = 34'(s_suit) * 34'(m_suit);

  assign div_dividend = {1'b0, s_num, 16'd0};
  assign div_divisor  = s_den;
  assign div_start    = st == F_SDIV && !div_busy && !div_done && s_need;

  shd_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign mid_valid = st == F_PUSH;
  assign mid_word  = '{suit: suit, time_q: tq};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= F_IDLE;
    end else begin
      unique case (st)
        F_IDLE: if (in_acc) st <= F_SDIV;
        F_SDIV: if (!s_need || div_done) st <= F_MDIV;
        F_MDIV: st <= F_MUL;
        F_MUL:  st <= F_PUSH;
        F_PUSH: if (!mid_full) st <= F_IDLE;
        default: st <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ang   <= ang_c;
      moist <= moist_c;
      tq    <= elapsed_time[31] ? 31'd0 : elapsed_time[30:0];
    end
    if (st == F_SDIV) begin
      if (!s_need) s_suit <= ang <= cfg.slope_full_limit ? 17'(ONE_Q16) : 17'd0;
      else if (div_done) s_suit <= 17'(ONE_Q16) - div_q;
    end
    if (st == F_MDIV) begin
      if (!m_need) begin
        m_suit <= (moist >= cfg.moisture_low_edge && moist <= cfg.moisture_high_edge)
                  ? 17'(ONE_Q16) : 17'd0;
      end else begin
        m_suit <= 17'(ONE_Q16) - m_q;
      end
    end
    if (st == F_MUL) suit <= prod[32:16];
  end
endmodule

### design/shd_queue.sv
// ----------------------------------------------------------------------------
// shd_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module shd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  shd_pkg::mid_t push_word,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output shd_pkg::mid_t pop_word
);
  import shd_pkg::*;

  mid_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full      = cnt == 2'd2;
  assign not_empty = cnt != 2'd0;
  assign pop_word  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push && !full) wp <= ~wp;
      if (pop && not_empty) rp <= ~rp;
      cnt <= cnt + 2'(push && !full) - 2'(pop && not_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem[wp] <= push_word;
  end
endmodule

### design/shd_back.sv
// ----------------------------------------------------------------------------
// shd_back
// hysteresis pick, debounce and output register
// ----------------------------------------------------------------------------
module shd_back (
  input  logic          clk,
  input  logic          rst,
  input  shd_pkg::cfg_t cfg,
  input  logic          q_valid,
  output logic          q_pop,
  input  shd_pkg::mid_t q_word,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [16:0]   pressure_ratio,
  output logic [16:0]   suitability_ratio,
  output logic [1:0]    region_state
);
  import shd_pkg::*;

  logic [1:0]  committed;
  logic [1:0]  pending;
  logic [30:0] duration;
  logic [1:0]  cand;
  logic [16:0] pres;
  logic [18:0] p2;
  logic [18:0] act_in;
  logic [18:0] act_out;
  logic [18:0] ovr_in;
  logic [18:0] ovr_out;
  logic        act_out_ok;
  logic        ovr_out_ok;
  logic        le_act;
  logic        le_ovr;
  logic        lt_ovr;
  logic [31:0] dsum;
  logic [30:0] dsat;
  logic [30:0] dbase;
  logic [1:0]  committed_next;
  logic [1:0]  pending_next;
  logic [30:0] duration_next;

  assign pres    = 17'(ONE_Q16) - q_word.suit;
  assign p2      = {1'b0, pres, 1'b0};
  assign act_in  = {1'b0, cfg.active_level, 1'b0} + {2'b0, cfg.band_width};
  assign ovr_in  = {1'b0, cfg.overuse_level, 1'b0} + {2'b0, cfg.band_width};
  assign act_out = {1'b0, cfg.active_level, 1'b0} - {2'b0, cfg.band_width};
  assign ovr_out = {1'b0, cfg.overuse_level, 1'b0} - {2'b0, cfg.band_width};
  assign act_out_ok = {1'b0, cfg.active_level, 1'b0} >= {2'b0, cfg.band_width};
  assign ovr_out_ok = {1'b0, cfg.overuse_level, 1'b0} >= {2'b0, cfg.band_width};
  assign le_act = act_out_ok && p2 <= act_out;
  assign le_ovr = ovr_out_ok && p2 <= ovr_out;
  assign lt_ovr = ovr_out_ok && p2 < ovr_out;

  always_comb begin
    unique case (committed)
      ST_UNUSED:   cand = p2 >= act_in ? ST_ACTIVE : ST_UNUSED;
      ST_ACTIVE:   cand = p2 >= ovr_in ? ST_OVERUSED : (le_act ? ST_UNUSED : ST_ACTIVE);
      ST_OVERUSED: cand = le_ovr ? ST_RECOVERING : ST_OVERUSED;
      default: begin
        if (p2 >= ovr_in) cand = ST_OVERUSED;
        else if (le_act) cand = ST_UNUSED;
        else cand = lt_ovr ? ST_ACTIVE : ST_RECOVERING;
      end
    endcase
  end

  assign dbase = cand != pending ? 31'd0 : duration;
  assign dsum  = {1'b0, dbase} + {1'b0, q_word.time_q};
  assign dsat  = dsum[31] ? 31'h7FFF_FFFF : dsum[30:0];

  always_comb begin
    committed_next = committed;
    pending_next   = committed;
    duration_next  = '0;
    if (cand != committed) begin
      if (dsat >= cfg.hold_time) begin
        committed_next = cand;
        pending_next   = cand;
      end else begin
        pending_next  = cand;
        duration_next = dsat;
      end
    end
  end

  assign q_pop = q_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      committed <= ST_UNUSED;
      pending   <= ST_UNUSED;
      duration  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        committed <= committed_next;
        pending   <= pending_next;
        duration  <= duration_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pressure_ratio    <= pres;
      suitability_ratio <= q_word.suit;
      region_state      <= committed_next;
    end
  end
endmodule

### design/suitability_hysteresis_debounce_top.sv
// ----------------------------------------------------------------------------
// suitability_hysteresis_debounce_top
// slope and moisture suitability, pressure, debounced four-state hysteresis
// ----------------------------------------------------------------------------
//  channel | signals                      | word
//  in      | in_valid / in_stall          | slope_angle, moisture_level, elapsed_time
//  out     | out_valid / out_stall        | pressure_ratio, suitability_ratio, region_state
//  cfg     | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// a word goes through F_SDIV, F_MDIV, F_MUL and F_PUSH in the front; the
// 17-step divider runs only on the slope ramp, moisture falloff is a reciprocal multiply
// the back takes one word a cycle from a two-entry queue while its output is not stalled
// reset is synchronous and returns config and control registers to their defaults
// out_stall backs up the queue, then the front holds in_stall
// ----------------------------------------------------------------------------
module suitability_hysteresis_debounce_top #(
  parameter int unsigned MOISTURE_TOLERANCE = shd_pkg::MOIST_TOL_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] slope_angle,
  input  logic signed [17:0] moisture_level,
  input  logic signed [31:0] elapsed_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [16:0]        pressure_ratio,
  output logic [16:0]        suitability_ratio,
  output logic [1:0]         region_state,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import shd_pkg::*;

  cfg_t cfg;
  logic mid_valid;
  logic mid_full;
  mid_t mid_word;
  logic q_pop;
  logic q_valid;
  mid_t q_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slope_full_limit   <= 15'd7680;
      cfg.slope_zero_limit   <= 15'd15360;
      cfg.moisture_low_edge  <= 17'd19661;
      cfg.moisture_high_edge <= 17'd45875;
      cfg.active_level       <= 17'd26214;
      cfg.overuse_level      <= 17'd45875;
      cfg.band_width         <= 17'd6554;
      cfg.hold_time          <= 31'd256;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SLOPE_FULL: cfg.slope_full_limit   <= cfg_data[14:0];
        REG_SLOPE_ZERO: cfg.slope_zero_limit   <= cfg_data[14:0];
        REG_MOIST_LOW:  cfg.moisture_low_edge  <= cfg_data[16:0];
        REG_MOIST_HIGH: cfg.moisture_high_edge <= cfg_data[16:0];
        REG_ACTIVE:     cfg.active_level       <= cfg_data[16:0];
        REG_OVERUSE:    cfg.overuse_level      <= cfg_data[16:0];
        REG_BAND:       cfg.band_width         <= cfg_data[16:0];
        REG_HOLD:       cfg.hold_time          <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  shd_front #(.MOISTURE_TOLERANCE(MOISTURE_TOLERANCE)) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .slope_angle    (slope_angle),
    .moisture_level (moisture_level),
    .elapsed_time   (elapsed_time),
    .mid_valid      (mid_valid),
    .mid_full       (mid_full),
    .mid_word       (mid_word)
  );

  shd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (mid_valid),
    .push_word (mid_word),
    .full      (mid_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_word  (q_word)
  );

  shd_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_word            (q_word),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .pressure_ratio    (pressure_ratio),
    .suitability_ratio (suitability_ratio),
    .region_state      (region_state)
  );
endmodule
